// ----- sv/bpfl_pkg.sv -----
// bpfl_pkg: shared types and constants of the buffer pool free list manager
package bpfl_pkg;

   // fixed field widths of the item and register interfaces
   localparam int TOKEN_W      = 9;
   localparam int COUNT_W      = 9;
   localparam int LEN_W        = 16;
   localparam int ADDR_FIELD_W = 48;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;

   // register reset values
   localparam logic [COUNT_W-1:0]      BUFFER_COUNT_RESET  = 9'd256;
   localparam logic [LEN_W-1:0]        BUFFER_LENGTH_RESET = 16'd2048;
   localparam logic [LEN_W-1:0]        HEADER_LENGTH_RESET = 16'd0;
   localparam logic [ADDR_FIELD_W-1:0] POOL_BASE_RESET     = 48'd0;

   // operation codes of an input item
   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_INIT   = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   // register indexes, byte address is 8 times the index
   typedef enum logic [1:0] {
      REG_BUFFER_COUNT  = 2'd0,
      REG_BUFFER_LENGTH = 2'd1,
      REG_HEADER_LENGTH = 2'd2,
      REG_POOL_BASE     = 2'd3
   } reg_type;

   // where a popped token comes from
   typedef enum logic [1:0] {
      POP_MEM     = 2'd0,
      POP_DEFAULT = 2'd1,
      POP_BYPASS  = 2'd2
   } pop_src_type;

   // live configuration
   typedef struct packed {
      logic [COUNT_W-1:0]      buffer_count;
      logic [LEN_W-1:0]        buffer_length;
      logic [LEN_W-1:0]        header_length;
      logic [ADDR_FIELD_W-1:0] pool_base;
   } cfg_type;

endpackage

// ----- sv/bpfl_csr.sv -----
// bpfl_csr: configuration registers behind the register port
module bpfl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bpfl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bpfl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bpfl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output bpfl_pkg::cfg_type                   cfg
);

   localparam int CW  = bpfl_pkg::COUNT_W;
   localparam int LW  = bpfl_pkg::LEN_W;
   localparam int AFW = bpfl_pkg::ADDR_FIELD_W;
   localparam int DW  = bpfl_pkg::CSR_DATA_W;

   bpfl_pkg::cfg_type  cfg_ff;
   bpfl_pkg::cfg_type  cfg_in;
   bpfl_pkg::reg_type  reg_sel;
   logic               wr_en;

   // register select from the 8-byte aligned address
   assign reg_sel = bpfl_pkg::reg_type'(paddr[bpfl_pkg::CSR_ADDR_W-1:3]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            bpfl_pkg::REG_BUFFER_COUNT:  cfg_in.buffer_count  = pwdata[CW-1:0];
            bpfl_pkg::REG_BUFFER_LENGTH: cfg_in.buffer_length = pwdata[LW-1:0];
            bpfl_pkg::REG_HEADER_LENGTH: cfg_in.header_length = pwdata[LW-1:0];
            bpfl_pkg::REG_POOL_BASE:     cfg_in.pool_base     = pwdata[AFW-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         bpfl_pkg::REG_BUFFER_COUNT:  prdata = DW'(cfg_ff.buffer_count);
         bpfl_pkg::REG_BUFFER_LENGTH: prdata = DW'(cfg_ff.buffer_length);
         bpfl_pkg::REG_HEADER_LENGTH: prdata = DW'(cfg_ff.header_length);
         bpfl_pkg::REG_POOL_BASE:     prdata = DW'(cfg_ff.pool_base);
         default:                     prdata = '0;
      endcase
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_count  <= bpfl_pkg::BUFFER_COUNT_RESET;
         cfg_ff.buffer_length <= bpfl_pkg::BUFFER_LENGTH_RESET;
         cfg_ff.header_length <= bpfl_pkg::HEADER_LENGTH_RESET;
         cfg_ff.pool_base     <= bpfl_pkg::POOL_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/buffer_pool_free_list_manager.sv -----
// buffer_pool_free_list_manager: top level of the buffer token allocator
//
//   port group  | direction | transfers
//   req_*       | in        | one operation item: op, token
//   rsp_*       | out       | one result item per operation
//   psel etc.   | in/out    | register writes and reads, 64-bit data
//
// one item per cycle unless held by the flag sweep, an init item or rsp_ready low;
// a result passes the operate stage with the stack and flag memory reads, the
// multiply stage and the address add into the result register; the single read port of each
// memory is used once per item, at the edge that takes it
// after reset req_ready stays low while the allocation flags are swept
// clear; an init item keeps it low from when it is taken, through its own
// operate stage and then the sweep
// rsp_ready low holds the result; the stages behind it keep filling
module buffer_pool_free_list_manager #(
   parameter int NUM_BUFFERS   = 256,
   parameter int ADDRESS_WIDTH = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   // operation items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic [bpfl_pkg::TOKEN_W-1:0]        req_token,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [bpfl_pkg::TOKEN_W-1:0]        rsp_token_out,
   output logic [bpfl_pkg::ADDR_FIELD_W-1:0]   rsp_header_address,
   output logic [bpfl_pkg::ADDR_FIELD_W-1:0]   rsp_data_address,
   output logic [bpfl_pkg::LEN_W-1:0]          rsp_data_length,
   output logic [bpfl_pkg::COUNT_W-1:0]        rsp_free_count,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bpfl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bpfl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bpfl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IDXW  = $clog2(NUM_BUFFERS);
   localparam int LVLW  = $clog2(NUM_BUFFERS + 1);
   localparam int CW    = bpfl_pkg::COUNT_W;
   localparam int TW    = bpfl_pkg::TOKEN_W;
   localparam int LW    = bpfl_pkg::LEN_W;
   localparam int AFW   = bpfl_pkg::ADDR_FIELD_W;
   localparam int AW    = ADDRESS_WIDTH;
   localparam int CNTW  = (LVLW > CW) ? LVLW : CW;
   localparam int PRODW = IDXW + LW;
   localparam int RESET_COUNT = (NUM_BUFFERS < int'(bpfl_pkg::BUFFER_COUNT_RESET)) ?
                                NUM_BUFFERS : int'(bpfl_pkg::BUFFER_COUNT_RESET);
   localparam logic [CNTW-1:0] NUM_C     = CNTW'(NUM_BUFFERS);
   localparam logic [LVLW-1:0] NUM_L     = LVLW'(NUM_BUFFERS);
   localparam logic [LVLW-1:0] RST_LVL   = LVLW'(RESET_COUNT);
   localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(NUM_BUFFERS - 1);

   bpfl_pkg::cfg_type cfg;

   // register bank
   bpfl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pool state
   logic [LVLW-1:0]   level_ff, level_in;
   logic [LVLW-1:0]   lowmark_ff, lowmark_in;
   logic              clear_ff, clear_in;
   logic [IDXW-1:0]   clr_idx_ff, clr_idx_in;

   // memories
   logic [CNTW-1:0]   stack_mem [NUM_BUFFERS];
   logic              flag_mem  [NUM_BUFFERS];
   logic [CNTW-1:0]   stack_rd_ff;
   logic              flag_rd_ff;

   // operate stage
   logic                      s1_valid_ff, s1_valid_in;
   bpfl_pkg::op_type          s1_op_ff;
   logic [TW-1:0]             s1_token_ff;
   bpfl_pkg::pop_src_type     s1_pop_src_ff, pop_src_in;
   logic [CNTW-1:0]           s1_alt_tok_ff, alt_tok_in;
   logic                      s1_flag_fwd_ff, flag_fwd_in;
   logic                      s1_flag_fwd_val_ff;

   // multiply stage
   logic                      s2_valid_ff, s2_valid_in;
   bpfl_pkg::status_type      s2_status_ff;
   logic [CNTW-1:0]           s2_tok_ff;
   logic                      s2_ok_ff;
   logic [CW-1:0]             s2_fcnt_ff;

   // address stage
   logic                      s3_valid_ff, s3_valid_in;
   bpfl_pkg::status_type      s3_status_ff;
   logic [TW-1:0]             s3_tok_ff;
   logic                      s3_ok_ff;
   logic [CW-1:0]             s3_fcnt_ff;
   logic [PRODW-1:0]          s3_prod_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   bpfl_pkg::status_type      rsp_status_ff;
   logic [TW-1:0]             rsp_token_ff;
   logic [AFW-1:0]            rsp_head_ff, rsp_data_ff;
   logic [LW-1:0]             rsp_len_ff;
   logic [CW-1:0]             rsp_fcnt_ff;

   // flow control
   logic rsp_load_ok, s3_free, s2_free, s1_free, commit, accept;

   assign rsp_load_ok = !rsp_valid_ff || rsp_ready;
   assign s3_free     = !s3_valid_ff || rsp_load_ok;
   assign s2_free     = !s2_valid_ff || s3_free;
   assign s1_free     = !s1_valid_ff || s2_free;
   assign commit      = s1_valid_ff && s2_free;
   assign req_ready   = s1_free && !clear_ff &&
                        !(s1_valid_ff && (s1_op_ff == bpfl_pkg::OP_INIT));
   assign accept      = req_valid && req_ready;

   // operate stage decision
   logic [CNTW-1:0]        count_c, tok_c, pop_tok;
   logic                   in_range, flag_cur;
   bpfl_pkg::status_type   res_status;
   logic [CNTW-1:0]        res_tok;
   logic                   res_ok, init_go;
   logic [LVLW-1:0]        lvl_calc, low_calc;
   logic                   stk_we, flg_we, flg_wd;
   logic [IDXW-1:0]        stk_wa, flg_wa;
   logic [CNTW-1:0]        stk_wd;

   always_comb begin
      count_c    = (CNTW'(cfg.buffer_count) > NUM_C) ? NUM_C : CNTW'(cfg.buffer_count);
      tok_c      = CNTW'(s1_token_ff);
      in_range   = (tok_c != '0) && (tok_c <= count_c);
      pop_tok    = (s1_pop_src_ff == bpfl_pkg::POP_MEM) ? stack_rd_ff : s1_alt_tok_ff;
      flag_cur   = s1_flag_fwd_ff ? s1_flag_fwd_val_ff : flag_rd_ff;
      res_status = bpfl_pkg::ST_OK;
      res_tok    = '0;
      res_ok     = 1'b0;
      init_go    = 1'b0;
      lvl_calc   = level_ff;
      low_calc   = lowmark_ff;
      stk_we     = 1'b0;
      stk_wa     = IDXW'(level_ff);
      stk_wd     = tok_c;
      flg_we     = 1'b0;
      flg_wa     = IDXW'(tok_c - 1'b1);
      flg_wd     = 1'b0;
      case (s1_op_ff)
         bpfl_pkg::OP_ALLOC: begin
            if (level_ff == '0) begin
               res_status = bpfl_pkg::ST_EMPTY;
            end else begin
               lvl_calc = level_ff - 1'b1;
               res_tok  = pop_tok;
               res_ok   = 1'b1;
               flg_we   = 1'b1;
               flg_wa   = IDXW'(pop_tok - 1'b1);
               flg_wd   = 1'b1;
            end
         end
         bpfl_pkg::OP_FREE: begin
            if (!in_range) begin
               res_status = bpfl_pkg::ST_RANGE;
            end else if (!flag_cur || (level_ff == NUM_L)) begin
               res_status = bpfl_pkg::ST_NOT_ALLOC;
            end else begin
               flg_we   = 1'b1;
               stk_we   = 1'b1;
               lvl_calc = level_ff + 1'b1;
               if (level_ff < lowmark_ff) begin
                  low_calc = level_ff;
               end
               res_tok  = tok_c;
               res_ok   = 1'b1;
            end
         end
         bpfl_pkg::OP_LOOKUP: begin
            if (!in_range) begin
               res_status = bpfl_pkg::ST_RANGE;
            end else begin
               res_tok = tok_c;
               res_ok  = 1'b1;
            end
         end
         bpfl_pkg::OP_INIT: begin
            lvl_calc = LVLW'(count_c);
            low_calc = NUM_L;
            init_go  = 1'b1;
         end
         default: ;
      endcase
   end

   // next pool state and read setup for the item being taken
   logic [LVLW-1:0] lvl_m1;
   logic [IDXW-1:0] stk_ra, req_idx;

   always_comb begin
      level_in   = commit ? lvl_calc : level_ff;
      lowmark_in = commit ? low_calc : lowmark_ff;
      lvl_m1     = level_in - 1'b1;
      stk_ra     = IDXW'(lvl_m1);
      req_idx    = IDXW'(CNTW'(req_token) - 1'b1);
      // a push this edge lands exactly where the next pop reads
      if (commit && stk_we) begin
         pop_src_in = bpfl_pkg::POP_BYPASS;
      end else if (lvl_m1 < lowmark_in) begin
         pop_src_in = bpfl_pkg::POP_DEFAULT;
      end else begin
         pop_src_in = bpfl_pkg::POP_MEM;
      end
      alt_tok_in  = (commit && stk_we) ? tok_c : CNTW'(level_in);
      flag_fwd_in = commit && flg_we && (flg_wa == req_idx);
   end

   // flag clearing sweep
   always_comb begin
      clear_in   = clear_ff;
      clr_idx_in = clr_idx_ff;
      if (clear_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clear_in = 1'b0;
         end
      end else if (commit && init_go) begin
         clear_in   = 1'b1;
         clr_idx_in = '0;
      end
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (commit && stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      if (accept) begin
         stack_rd_ff <= stack_mem[stk_ra];
      end
   end

   // allocation flag memory
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         flag_mem[clr_idx_ff] <= 1'b0;
      end else if (commit && flg_we) begin
         flag_mem[flg_wa] <= flg_wd;
      end
      if (accept) begin
         flag_rd_ff <= flag_mem[req_idx];
      end
   end

   // stage valids
   always_comb begin
      s1_valid_in  = s1_free ? accept : s1_valid_ff;
      s2_valid_in  = s2_free ? commit : s2_valid_ff;
      s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = rsp_load_ok ? s3_valid_ff : rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= RST_LVL;
         lowmark_ff   <= NUM_L;
         clear_ff     <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         lowmark_ff   <= lowmark_in;
         clear_ff     <= clear_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operate stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff           <= bpfl_pkg::op_type'(req_op);
         s1_token_ff        <= req_token;
         s1_pop_src_ff      <= pop_src_in;
         s1_alt_tok_ff      <= alt_tok_in;
         s1_flag_fwd_ff     <= flag_fwd_in;
         s1_flag_fwd_val_ff <= flg_wd;
      end
   end

   // multiply stage payload
   always_ff @(posedge clock) begin
      if (commit) begin
         s2_status_ff <= res_status;
         s2_tok_ff    <= res_tok;
         s2_ok_ff     <= res_ok;
         s2_fcnt_ff   <= CW'(lvl_calc);
      end
   end

   // buffer offset from the token
   logic [IDXW-1:0]  tok_idx;
   logic [PRODW-1:0] prod_c;

   assign tok_idx = IDXW'(s2_tok_ff - 1'b1);
   assign prod_c  = PRODW'(tok_idx) * PRODW'(cfg.buffer_length);

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_free) begin
         s3_status_ff <= s2_status_ff;
         s3_tok_ff    <= TW'(s2_tok_ff);
         s3_ok_ff     <= s2_ok_ff;
         s3_fcnt_ff   <= s2_fcnt_ff;
         s3_prod_ff   <= prod_c;
      end
   end

   // header and data addresses, wrapped to the address width
   logic [AW-1:0] head_c, data_c;
   logic [LW-1:0] len_c;

   always_comb begin
      head_c = AW'(cfg.pool_base) + AW'(s3_prod_ff);
      data_c = AW'(cfg.pool_base) + AW'(s3_prod_ff) + AW'(cfg.header_length);
      len_c  = (cfg.header_length > cfg.buffer_length) ? '0 :
               cfg.buffer_length - cfg.header_length;
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && rsp_load_ok) begin
         rsp_status_ff <= s3_status_ff;
         rsp_token_ff  <= s3_ok_ff ? s3_tok_ff : '0;
         rsp_head_ff   <= s3_ok_ff ? AFW'(head_c) : '0;
         rsp_data_ff   <= s3_ok_ff ? AFW'(data_c) : '0;
         rsp_len_ff    <= s3_ok_ff ? len_c : '0;
         rsp_fcnt_ff   <= s3_fcnt_ff;
      end
   end

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_token_out      = rsp_token_ff;
   assign rsp_header_address = rsp_head_ff;
   assign rsp_data_address   = rsp_data_ff;
   assign rsp_data_length    = rsp_len_ff;
   assign rsp_free_count     = rsp_fcnt_ff;

endmodule

// ----- sv/bpfl_checker.sv -----
// bpfl_checker: port-level assertions for the buffer pool free list manager
module bpfl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic [bpfl_pkg::TOKEN_W-1:0]        rsp_token_out,
   input logic [bpfl_pkg::ADDR_FIELD_W-1:0]   rsp_header_address,
   input logic [bpfl_pkg::ADDR_FIELD_W-1:0]   rsp_data_address,
   input logic [bpfl_pkg::LEN_W-1:0]          rsp_data_length,
   input logic [bpfl_pkg::COUNT_W-1:0]        rsp_free_count
);

   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a failed item carries no token and no buffer description
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bpfl_pkg::ST_OK) |->
         (rsp_token_out == '0) && (rsp_header_address == '0) &&
         (rsp_data_address == '0) && (rsp_data_length == '0))
      else $error("failed item carries buffer fields");

   // an empty pool reports no free buffers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bpfl_pkg::ST_EMPTY) |-> (rsp_free_count == '0))
      else $error("empty status with free buffers left");

   // the flag sweep after reset keeps the input closed and no result pending
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("items taken or results shown right after reset");

endmodule

bind buffer_pool_free_list_manager bpfl_checker u_bpfl_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_token_out      (rsp_token_out),
   .rsp_header_address (rsp_header_address),
   .rsp_data_address   (rsp_data_address),
   .rsp_data_length    (rsp_data_length),
   .rsp_free_count     (rsp_free_count)
);

// ----- tb/sv/bpfl_result_checker.sv -----
// bpfl_result_checker: predicts and checks the results of the buffer pool free list manager
`timescale 1ns / 100ps

module bpfl_result_checker
   import bpfl_pkg::*;
#(
   parameter int NUM_BUFFERS   = 256,
   parameter int ADDRESS_WIDTH = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [1:0]              req_op,
   input  logic [TOKEN_W-1:0]      req_token,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [1:0]              rsp_status,
   input  logic [TOKEN_W-1:0]      rsp_token_out,
   input  logic [ADDR_FIELD_W-1:0] rsp_header_address,
   input  logic [ADDR_FIELD_W-1:0] rsp_data_address,
   input  logic [LEN_W-1:0]        rsp_data_length,
   input  logic [COUNT_W-1:0]      rsp_free_count,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   input  logic                    pready,
   output int                      mismatches,
   output int                      pending,
   output int                      results_seen
);

   // addresses wrap at the build's address width
   localparam logic [63:0] ADDR_MASK =
      (ADDRESS_WIDTH >= 64) ? '1 : ((64'd1 << ADDRESS_WIDTH) - 64'd1);

   typedef struct packed {
      status_type              status;
      logic [TOKEN_W-1:0]      token_out;
      logic [ADDR_FIELD_W-1:0] header_address;
      logic [ADDR_FIELD_W-1:0] data_address;
      logic [LEN_W-1:0]        data_length;
      logic [COUNT_W-1:0]      free_count;
   } pool_result_type;

   // predicted pool state and live registers
   cfg_type            pool_cfg;
   logic [TOKEN_W-1:0] stacked_tokens [NUM_BUFFERS];
   bit                 token_taken [NUM_BUFFERS];
   int unsigned        stack_depth;
   pool_result_type    pool_results_due [$];

   // buffers actually usable under the live count
   function automatic int unsigned usable_count();
      return (pool_cfg.buffer_count > NUM_BUFFERS) ? NUM_BUFFERS : int'(pool_cfg.buffer_count);
   endfunction

   // every buffer free again, stack holds 1..N with the highest on top
   function automatic void restock();
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         stacked_tokens[i] = TOKEN_W'(i + 1);
         token_taken[i]    = 1'b0;
      end
      stack_depth = usable_count();
   endfunction

   // memory placement of one buffer
   function automatic pool_result_type place_buffer(logic [TOKEN_W-1:0] tok);
      pool_result_type r;
      logic [63:0]     head;
      logic [63:0]     data;
      r    = '0;
      head = (64'(pool_cfg.pool_base) + (64'(tok) - 64'd1) * 64'(pool_cfg.buffer_length))
             & ADDR_MASK;
      data = (head + 64'(pool_cfg.header_length)) & ADDR_MASK;
      r.token_out      = tok;
      r.header_address = head[ADDR_FIELD_W-1:0];
      r.data_address   = data[ADDR_FIELD_W-1:0];
      r.data_length    = (pool_cfg.header_length > pool_cfg.buffer_length) ? '0 :
                         pool_cfg.buffer_length - pool_cfg.header_length;
      return r;
   endfunction

   // one pool operation: update the predicted state and give its result
   function automatic pool_result_type apply_operation(op_type op, logic [TOKEN_W-1:0] tok);
      pool_result_type    r;
      int unsigned        n;
      bit                 in_range;
      logic [TOKEN_W-1:0] popped;
      r        = '0;
      n        = usable_count();
      in_range = (tok != 0) && (tok <= n);
      case (op)
         OP_ALLOC: begin
            if (stack_depth == 0 || stack_depth > NUM_BUFFERS) begin
               r.status = ST_EMPTY;
            end else begin
               stack_depth--;
               popped = stacked_tokens[stack_depth];
               if (popped >= 1 && popped <= NUM_BUFFERS) token_taken[popped - 1] = 1'b1;
               r = place_buffer(popped);
            end
         end
         OP_FREE: begin
            if (!in_range) begin
               r.status = ST_RANGE;
            end else if (!token_taken[tok - 1] || stack_depth >= NUM_BUFFERS) begin
               r.status = ST_NOT_ALLOC;
            end else begin
               token_taken[tok - 1]        = 1'b0;
               stacked_tokens[stack_depth] = tok;
               stack_depth++;
               r = place_buffer(tok);
            end
         end
         OP_LOOKUP: begin
            if (!in_range) r.status = ST_RANGE;
            else r = place_buffer(tok);
         end
         default: restock();
      endcase
      r.free_count = COUNT_W'(stack_depth);
      return r;
   endfunction

   // report one differing field
   function automatic bit field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (want === got) return 1'b0;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch_channels
      pool_result_type want;
      bit              bad;
      if (reset) begin
         pool_cfg.buffer_count  = BUFFER_COUNT_RESET;
         pool_cfg.buffer_length = BUFFER_LENGTH_RESET;
         pool_cfg.header_length = HEADER_LENGTH_RESET;
         pool_cfg.pool_base     = POOL_BASE_RESET;
         restock();
         pool_results_due.delete();
         mismatches   <= 0;
         results_seen <= 0;
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_type'(paddr[CSR_ADDR_W-1:3]))
               REG_BUFFER_COUNT:  pool_cfg.buffer_count  = pwdata[COUNT_W-1:0];
               REG_BUFFER_LENGTH: pool_cfg.buffer_length = pwdata[LEN_W-1:0];
               REG_HEADER_LENGTH: pool_cfg.header_length = pwdata[LEN_W-1:0];
               REG_POOL_BASE:     pool_cfg.pool_base     = pwdata[ADDR_FIELD_W-1:0];
               default: ;
            endcase
         end

         // result items against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (pool_results_due.size() == 0) begin
               $display("%0t: result item with nothing expected, status %0d token %0d",
                        $time, rsp_status, rsp_token_out);
               mismatches <= mismatches + 1;
            end else begin
               want = pool_results_due.pop_front();
               bad  = field_differs("status", want.status, rsp_status)
                    | field_differs("token_out", want.token_out, rsp_token_out)
                    | field_differs("header_address", want.header_address, rsp_header_address)
                    | field_differs("data_address", want.data_address, rsp_data_address)
                    | field_differs("data_length", want.data_length, rsp_data_length)
                    | field_differs("free_count", want.free_count, rsp_free_count);
               if (bad) mismatches <= mismatches + 1;
            end
         end

         // operation items into the predictor
         if (req_valid && req_ready)
            pool_results_due.push_back(apply_operation(op_type'(req_op), req_token));
      end
      pending <= pool_results_due.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// tb: stimulus, register setup and verdict for the buffer pool free list manager
`timescale 1ns / 100ps

module tb;
   import bpfl_pkg::*;

   localparam int NUM_BUFFERS   = 256;
   localparam int ADDRESS_WIDTH = 48;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_op = '0;
   logic [TOKEN_W-1:0]      req_token = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [TOKEN_W-1:0]      rsp_token_out;
   logic [ADDR_FIELD_W-1:0] rsp_header_address;
   logic [ADDR_FIELD_W-1:0] rsp_data_address;
   logic [LEN_W-1:0]        rsp_data_length;
   logic [COUNT_W-1:0]      rsp_free_count;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int mismatches;
   int pending;
   int results_seen;

   bit steady         = 1'b0;
   int items_sent     = 0;
   int inits_sent     = 0;
   int settings_used  = 1;

   always #5 clock = ~clock;

   // result side stalls at random except during the steady stretch
   always @(posedge clock) rsp_ready <= steady || ($urandom_range(99) >= 24);

   buffer_pool_free_list_manager #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .ADDRESS_WIDTH(ADDRESS_WIDTH)
   ) dut (.*);

   bpfl_result_checker #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .ADDRESS_WIDTH(ADDRESS_WIDTH)
   ) checker_inst (.*);

   // one operation item, with a random gap ahead of it outside the steady stretch
   task automatic send_op(input op_type op, input logic [TOKEN_W-1:0] tok);
      if (!steady) begin
         while ($urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_token <= tok;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (op == OP_INIT) inits_sent++;
   endtask

   // stop sending, wait for every result, then let an init sweep finish
   task automatic drain_pool_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (NUM_BUFFERS + 16) @(posedge clock);
   endtask

   // setup and access phase of one register write, psel left high
   task automatic write_reg(input reg_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // all four registers, written only with the pool idle
   task automatic configure_pool(input logic [COUNT_W-1:0] count, input logic [LEN_W-1:0] blen,
                                 input logic [LEN_W-1:0] hlen,
                                 input logic [ADDR_FIELD_W-1:0] base);
      drain_pool_results();
      write_reg(REG_BUFFER_COUNT, CSR_DATA_W'(count));
      write_reg(REG_BUFFER_LENGTH, CSR_DATA_W'(blen));
      write_reg(REG_HEADER_LENGTH, CSR_DATA_W'(hlen));
      write_reg(REG_POOL_BASE, CSR_DATA_W'(base));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   // mostly tokens inside the pool, sometimes anything the field holds
   function automatic logic [TOKEN_W-1:0] pick_token(input int n);
      return ($urandom_range(99) < 85) ? TOKEN_W'($urandom_range(1, n)) :
                                         TOKEN_W'($urandom_range(511));
   endfunction

   // runs of allocs and frees with lookups and the odd init between them
   task automatic random_ops(input int quota, input int n);
      int done;
      int pick;
      int run;
      done = 0;
      while (done < quota) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            run = ($urandom_range(9) == 0) ? n + 2 : $urandom_range(1, 6);
            for (int k = 0; k < run && done < quota; k++) begin
               send_op(OP_ALLOC, TOKEN_W'($urandom_range(511)));
               done++;
            end
         end else if (pick < 80) begin
            run = $urandom_range(1, 6);
            for (int k = 0; k < run && done < quota; k++) begin
               send_op(OP_FREE, pick_token(n));
               done++;
            end
         end else if (pick < 96) begin
            send_op(OP_LOOKUP, pick_token(n));
            done++;
         end else begin
            send_op(OP_INIT, TOKEN_W'($urandom_range(511)));
            done++;
         end
      end
   endtask

   initial begin
      logic [COUNT_W-1:0]      count;
      logic [LEN_W-1:0]        blen;
      logic [LEN_W-1:0]        hlen;
      logic [ADDR_FIELD_W-1:0] base;
      int                      n;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: top of the stack, range edges, double free
      send_op(OP_ALLOC, '0);
      send_op(OP_ALLOC, '0);
      send_op(OP_LOOKUP, 9'd256);
      send_op(OP_LOOKUP, 9'd0);
      send_op(OP_LOOKUP, 9'h1FF);
      send_op(OP_FREE, 9'd256);
      send_op(OP_FREE, 9'd256);
      send_op(OP_FREE, 9'd0);
      send_op(OP_FREE, 9'd257);
      send_op(OP_ALLOC, '0);

      // tiny pool at the top of the address space, count cut to zero without init
      configure_pool(9'd3, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_op(OP_INIT, '0);
      send_op(OP_ALLOC, '0);
      send_op(OP_LOOKUP, 9'd1);
      configure_pool(9'd0, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, 9'd2);
      send_op(OP_LOOKUP, 9'd1);
      send_op(OP_INIT, '0);
      send_op(OP_ALLOC, '0);

      // count above the build, header longer than the buffer
      configure_pool(9'd511, 16'd50, 16'd100, 48'd0);
      send_op(OP_INIT, '0);
      send_op(OP_LOOKUP, 9'd256);
      send_op(OP_ALLOC, '0);
      send_op(OP_LOOKUP, 9'd257);
      send_op(OP_FREE, 9'd256);

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         blen = LEN_W'($urandom_range(1, 65535));
         hlen = LEN_W'($urandom_range(65535));
         base = ADDR_FIELD_W'({$urandom(), $urandom()});
         case (p)
            0: begin
               count = 9'd256;
               hlen  = LEN_W'($urandom_range(0, blen));
            end
            1: begin
               count = 9'd1;
               blen  = 16'd1;
               hlen  = 16'd0;
               base  = 48'hFFFF_FFFF_FFFF;
            end
            2: count = COUNT_W'($urandom_range(2, 16));
            3: begin
               count = COUNT_W'($urandom_range(17, 255));
               blen  = 16'hFFFF;
               hlen  = 16'd0;
            end
            4: begin
               count = COUNT_W'($urandom_range(257, 511));
               base  = 48'd0;
            end
            default: count = COUNT_W'($urandom_range(2, 8));
         endcase
         configure_pool(count, blen, hlen, base);
         n = (count > NUM_BUFFERS) ? NUM_BUFFERS : int'(count);
         steady = (p == 3);
         send_op(OP_INIT, '0);
         random_ops(235, n);
      end
      steady = 1'b0;

      drain_pool_results();
      $display("covered %0d operations including %0d pool inits, under %0d register settings",
               items_sent, inits_sent, settings_used);
      $display("%0d result items compared field by field", results_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("run limit reached with %0d results outstanding", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
